// File: hw/rtl/iccpx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iccpx_pkg
// Types and constants shared by the PNG iCCP chunk extractor modules.
// ----------------------------------------------------------------------------
package iccpx_pkg;

   // Parse phases of the chunk walker.
   typedef enum logic [3:0] {
      PH_SIG,
      PH_LEN,
      PH_TYPE,
      PH_NAME,
      PH_METHOD,
      PH_PAYLOAD,
      PH_SKIP,
      PH_BADSKIP,
      PH_CRC,
      PH_CRC_BAD
   } phase_type;

   // Closing status codes.
   typedef enum logic [2:0] {
      ST_OK,
      ST_SIGNATURE,
      ST_NO_ICCP,
      ST_TRUNCATED,
      ST_MALFORMED
   } status_type;

   // One result item as produced by the parser.
   typedef struct packed {
      logic       valid;
      logic [7:0] payload_byte;
      logic       is_end;
      status_type status;
   } result_type;

   localparam logic [7:0] PNG_SIG [8] = '{
      8'h89, 8'h50, 8'h4e, 8'h47, 8'h0d, 8'h0a, 8'h1a, 8'h0a
   };

   localparam logic [31:0] TYPE_ICCP = 32'h6943_4350;
   localparam logic [31:0] TYPE_IEND = 32'h4945_4e44;
   localparam logic [4:0]  MIN_FILE  = 5'd20;
   localparam logic [2:0]  HDR_TAIL  = 3'd4;

endpackage

// File: hw/rtl/iccpx_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iccpx_if
// Valid/ready channels for file bytes in and extracted items out.
// ----------------------------------------------------------------------------
interface iccpx_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface iccpx_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] payload_byte;
   logic       is_end;
   logic [2:0] status;

   modport source (output valid, output payload_byte, output is_end, output status,
                   input ready);
   modport sink   (input valid, input payload_byte, input is_end, input status,
                   output ready);
endinterface

// File: hw/rtl/iccpx_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iccpx_parser
// Byte-wide PNG chunk walker: signature check, chunk headers, iCCP payload.
// ----------------------------------------------------------------------------
module iccpx_parser
   import iccpx_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_fire,
   input  logic [7:0] data_byte,
   input  logic       last_byte,
   output result_type res
);

   phase_type   phase_ff,      phase_in;
   logic [4:0]  file_count_ff, file_count_in;
   logic [1:0]  field_idx_ff,  field_idx_in;
   logic [31:0] chunk_len_ff,  chunk_len_in;
   logic [31:0] chunk_type_ff, chunk_type_in;
   logic [31:0] bytes_left_ff, bytes_left_in;
   logic [2:0]  seen_ff,       seen_in;
   logic        finished_ff,   finished_in;

   logic [4:0]  fc_inc;
   logic [31:0] left_dec;
   logic        data_done;
   logic [2:0]  seen_inc;
   logic [31:0] len_shift;
   logic [31:0] type_shift;
   logic        idx_wrap;
   logic        end_hit;
   logic        pay_hit;
   status_type  end_status;
   logic        in_body;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SIG;
         file_count_ff <= '0;
         field_idx_ff  <= '0;
         seen_ff       <= '0;
         finished_ff   <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         file_count_ff <= file_count_in;
         field_idx_ff  <= field_idx_in;
         seen_ff       <= seen_in;
         finished_ff   <= finished_in;
      end
   end

   // Length, type and byte count are always loaded before they are read.
   always_ff @(posedge clock) begin
      chunk_len_ff  <= chunk_len_in;
      chunk_type_ff <= chunk_type_in;
      bytes_left_ff <= bytes_left_in;
   end

   always_comb begin
      phase_in      = phase_ff;
      file_count_in = file_count_ff;
      field_idx_in  = field_idx_ff;
      chunk_len_in  = chunk_len_ff;
      chunk_type_in = chunk_type_ff;
      bytes_left_in = bytes_left_ff;
      seen_in       = seen_ff;
      finished_in   = finished_ff;

      fc_inc     = (file_count_ff < MIN_FILE) ? file_count_ff + 5'd1 : file_count_ff;
      left_dec   = (bytes_left_ff == '0) ? '0 : bytes_left_ff - 32'd1;
      data_done  = (bytes_left_ff <= 32'd1);
      seen_inc   = (seen_ff == HDR_TAIL) ? HDR_TAIL : seen_ff + 3'd1;
      len_shift  = {chunk_len_ff[23:0], data_byte};
      type_shift = {chunk_type_ff[23:0], data_byte};
      idx_wrap   = (field_idx_ff == 2'd3);
      end_hit    = 1'b0;
      pay_hit    = 1'b0;
      end_status = ST_OK;
      in_body    = 1'b0;

      if (in_fire) begin
         if (finished_ff) begin
            if (last_byte) begin
               phase_in      = PH_SIG;
               file_count_in = '0;
               field_idx_in  = '0;
               seen_in       = '0;
               finished_in   = 1'b0;
            end
         end else begin
            file_count_in = fc_inc;
            unique case (phase_ff)
               PH_SIG: begin
                  // In this phase the count is below eight, so its low bits
                  // give the position within the signature.
                  if (data_byte != PNG_SIG[file_count_ff[2:0]]) begin
                     end_hit    = 1'b1;
                     end_status = ST_SIGNATURE;
                  end else if (file_count_ff[2:0] == 3'd7) begin
                     phase_in     = PH_LEN;
                     field_idx_in = '0;
                  end
               end
               PH_LEN: begin
                  chunk_len_in = len_shift;
                  field_idx_in = field_idx_ff + 2'd1;
                  if (idx_wrap) begin
                     phase_in = PH_TYPE;
                  end
               end
               PH_TYPE: begin
                  chunk_type_in = type_shift;
                  field_idx_in  = field_idx_ff + 2'd1;
                  if (idx_wrap) begin
                     bytes_left_in = chunk_len_ff;
                     seen_in       = '0;
                     if (type_shift == TYPE_ICCP) begin
                        if (chunk_len_ff < 32'd3) begin
                           phase_in = (chunk_len_ff == '0) ? PH_CRC_BAD : PH_BADSKIP;
                        end else begin
                           phase_in = PH_NAME;
                        end
                     end else begin
                        phase_in = (chunk_len_ff == '0) ? PH_CRC : PH_SKIP;
                     end
                  end
               end
               PH_NAME: begin
                  bytes_left_in = left_dec;
                  seen_in       = seen_inc;
                  if (data_done) begin
                     phase_in = PH_CRC_BAD;
                  end else if (data_byte == 8'd0) begin
                     phase_in = PH_METHOD;
                  end
               end
               PH_METHOD: begin
                  bytes_left_in = left_dec;
                  seen_in       = seen_inc;
                  if (data_done) begin
                     phase_in = PH_CRC_BAD;
                  end else if (data_byte != 8'd0) begin
                     phase_in = PH_BADSKIP;
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end
               PH_PAYLOAD: begin
                  bytes_left_in = left_dec;
                  seen_in       = seen_inc;
                  pay_hit       = 1'b1;
                  if (data_done) begin
                     phase_in = PH_CRC;
                  end
               end
               PH_SKIP: begin
                  bytes_left_in = left_dec;
                  seen_in       = seen_inc;
                  if (data_done) begin
                     phase_in = PH_CRC;
                  end
               end
               PH_BADSKIP: begin
                  bytes_left_in = left_dec;
                  seen_in       = seen_inc;
                  if (data_done) begin
                     phase_in = PH_CRC_BAD;
                  end
               end
               PH_CRC, PH_CRC_BAD: begin
                  field_idx_in = field_idx_ff + 2'd1;
                  seen_in      = seen_inc;
                  if (idx_wrap) begin
                     if (phase_ff == PH_CRC_BAD) begin
                        end_hit    = 1'b1;
                        end_status = ST_MALFORMED;
                     end else if (chunk_type_ff == TYPE_ICCP) begin
                        end_hit    = 1'b1;
                        end_status = ST_OK;
                     end else if (chunk_type_ff == TYPE_IEND) begin
                        end_hit    = 1'b1;
                        end_status = ST_NO_ICCP;
                     end else begin
                        phase_in = PH_LEN;
                     end
                  end
               end
               default: begin
               end
            endcase

            // End of file before a decision: the saturating count of bytes past
            // the chunk header tells truncation from a clean chunk boundary.
            if (!end_hit && last_byte) begin
               in_body = (phase_in >= PH_NAME) && (phase_in <= PH_CRC_BAD);
               end_hit = 1'b1;
               if ((fc_inc < MIN_FILE) || (phase_in == PH_SIG)) begin
                  end_status = ST_SIGNATURE;
               end else if (in_body && (seen_in >= HDR_TAIL)) begin
                  end_status = ST_TRUNCATED;
               end else begin
                  end_status = ST_NO_ICCP;
               end
            end

            if (end_hit) begin
               if (last_byte) begin
                  phase_in      = PH_SIG;
                  file_count_in = '0;
                  field_idx_in  = '0;
                  seen_in       = '0;
                  finished_in   = 1'b0;
               end else begin
                  finished_in = 1'b1;
               end
            end
         end
      end

      res.valid        = end_hit || pay_hit;
      res.payload_byte = end_hit ? 8'd0 : data_byte;
      res.is_end       = end_hit;
      res.status       = end_hit ? end_status : ST_OK;
   end

endmodule

// File: hw/rtl/iccpx_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iccpx_out_buf
// Two-entry output register with skid stage; ready toward the parser is
// registered.
// ----------------------------------------------------------------------------
module iccpx_out_buf
   import iccpx_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  result_type       push_item,
   output logic             in_ready,
   iccpx_rsp_if.source      rsp
);

   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type main_ff,       main_in;
   result_type skid_ff,       skid_in;
   logic       push;
   logic       pop;

   assign push     = push_item.valid;
   assign pop      = main_valid_ff && rsp.ready;
   assign in_ready = !skid_valid_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_in       = push_item;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = push_item;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp.valid        = main_valid_ff;
   assign rsp.payload_byte = main_ff.payload_byte;
   assign rsp.is_end       = main_ff.is_end;
   assign rsp.status       = main_ff.status;

endmodule

// File: hw/rtl/png_iccp_chunk_extractor.sv
`timescale 1ns / 1ps
// Results are registered into the output stage (main entry, or skid while main
// stalls). Throughput: one byte per cycle while skid is empty; parser state
// updates in the transfer cycle and two entries absorb back-pressure.
// Reset: synchronous, active high; returns to the signature phase with the
// output stage empty. A flagged last byte also returns the parser to that phase.
// ----------------------------------------------------------------------------
// png_iccp_chunk_extractor
// Walks a PNG byte stream and passes out the compressed iCCP profile bytes,
// followed by one closing status item.
// ----------------------------------------------------------------------------
module png_iccp_chunk_extractor
   import iccpx_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   iccpx_req_if.sink    req_ch,
   iccpx_rsp_if.source  rsp_ch
);

   logic       in_fire;
   logic       buf_ready;
   result_type res;

   assign req_ch.ready = buf_ready;
   assign in_fire      = req_ch.valid && buf_ready;

   iccpx_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .in_fire   (in_fire),
      .data_byte (req_ch.data_byte),
      .last_byte (req_ch.last_byte),
      .res       (res)
   );

   iccpx_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push_item (res),
      .in_ready  (buf_ready),
      .rsp       (rsp_ch)
   );

endmodule

// File: hw/rtl/iccpx_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iccpx_checker
// Port-level checks on the extractor, attached to the top level by bind.
// ----------------------------------------------------------------------------
module iccpx_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_payload_byte,
   input logic       rsp_is_end,
   input logic [2:0] rsp_status
);

   // Reset empties the output stage.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown right after reset");

   // A newly shown result must come from a byte transferred the cycle before.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(rsp_valid)) |-> $past(req_valid && req_ready))
      else $error("result without a preceding input transfer");

   // With nothing waiting at the output, the input side must be open.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with an empty output stage");

   // A stalled result holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_payload_byte) && $stable(rsp_is_end)
          && $stable(rsp_status)))
      else $error("stalled result changed");

endmodule

bind png_iccp_chunk_extractor iccpx_checker u_iccpx_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_payload_byte (rsp_ch.payload_byte),
   .rsp_is_end       (rsp_ch.is_end),
   .rsp_status       (rsp_ch.status)
);

// File: verif/tb_png_iccp_chunk_extractor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_png_iccp_chunk_extractor
// Streams PNG files through the iCCP chunk extractor: first a short directed
// file set, then random files, some well formed and the rest broken or noise.
// A byte-level model of the chunk walker predicts payload bytes and closing status
// (directed rows may give them instead), and the monitor checks each result.
// ----------------------------------------------------------------------------
module tb_png_iccp_chunk_extractor
   import iccpx_pkg::*;
();

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       is_end;
      status_type status;
   } profile_item_type;

   typedef enum logic [1:0] {
      ROW_PREDICT, ROW_NONE, ROW_PAYLOAD, ROW_STATUS
   } row_kind_type;

   typedef struct packed {
      logic [7:0]   data_byte;
      logic         last_byte;
      row_kind_type kind;
      logic [7:0]   exp_byte;
      status_type   exp_status;
   } directed_row_type;

   localparam int NUM_ROWS     = 27;
   localparam int RANDOM_BYTES = 2000;
   localparam int DRAIN_LIMIT  = 20000;
   localparam int LONG_HOLD    = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #5 clock = ~clock;

   iccpx_req_if req_ch();
   iccpx_rsp_if rsp_ch();

   png_iccp_chunk_extractor dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // A bad first byte, ignored bytes up to a flagged last byte, a one-byte file, then a
   // minimal file whose profile chunk carries an empty name and one byte.
   directed_row_type directed_rows [NUM_ROWS] = '{
      '{8'h00, 1'b0, ROW_STATUS,  8'h00, ST_SIGNATURE},
      '{8'hff, 1'b0, ROW_NONE,    8'h00, ST_OK},
      '{8'hff, 1'b1, ROW_NONE,    8'h00, ST_OK},
      '{8'h89, 1'b1, ROW_STATUS,  8'h00, ST_SIGNATURE},
      '{8'h89, 1'b0, ROW_NONE,    8'h00, ST_OK},
      '{8'h50, 1'b0, ROW_NONE,    8'h00, ST_OK},
      '{8'h4e, 1'b0, ROW_NONE,    8'h00, ST_OK},
      '{8'h47, 1'b0, ROW_NONE,    8'h00, ST_OK},
      '{8'h0d, 1'b0, ROW_NONE,    8'h00, ST_OK},
      '{8'h0a, 1'b0, ROW_NONE,    8'h00, ST_OK},
      '{8'h1a, 1'b0, ROW_NONE,    8'h00, ST_OK},
      '{8'h0a, 1'b0, ROW_NONE,    8'h00, ST_OK},
      '{8'h00, 1'b0, ROW_PREDICT, 8'h00, ST_OK},
      '{8'h00, 1'b0, ROW_PREDICT, 8'h00, ST_OK},
      '{8'h00, 1'b0, ROW_PREDICT, 8'h00, ST_OK},
      '{8'h03, 1'b0, ROW_PREDICT, 8'h00, ST_OK},
      '{8'h69, 1'b0, ROW_PREDICT, 8'h00, ST_OK},
      '{8'h43, 1'b0, ROW_PREDICT, 8'h00, ST_OK},
      '{8'h43, 1'b0, ROW_PREDICT, 8'h00, ST_OK},
      '{8'h50, 1'b0, ROW_PREDICT, 8'h00, ST_OK},
      '{8'h00, 1'b0, ROW_PREDICT, 8'h00, ST_OK},
      '{8'h00, 1'b0, ROW_PREDICT, 8'h00, ST_OK},
      '{8'hff, 1'b0, ROW_PAYLOAD, 8'hff, ST_OK},
      '{8'h00, 1'b0, ROW_PREDICT, 8'h00, ST_OK},
      '{8'hff, 1'b0, ROW_PREDICT, 8'h00, ST_OK},
      '{8'h5a, 1'b0, ROW_PREDICT, 8'h00, ST_OK},
      '{8'ha5, 1'b1, ROW_STATUS,  8'h00, ST_OK}
   };

   // Chunk walker state of the predictor.
   phase_type   walk_phase;
   logic [4:0]  byte_tally;
   logic [1:0]  word_pos;
   logic [31:0] walk_len;
   logic [31:0] chunk_tag;
   logic [31:0] data_left;
   logic        run_closed;

   profile_item_type profile_q [$];
   logic [7:0]       file_q [$];
   logic [7:0]       body_q [$];
   int               mismatches   = 0;
   int               results_seen = 0;
   int               live_bytes   = 0;

   function automatic void clear_walker();
      walk_phase = PH_SIG;
      byte_tally = '0;
      word_pos   = '0;
      walk_len   = '0;
      chunk_tag  = '0;
      data_left  = '0;
      run_closed = 1'b0;
   endfunction

   function automatic void open_chunk_data(phase_type data_phase, phase_type crc_phase);
      data_left  = walk_len;
      walk_phase = (walk_len == 0) ? crc_phase : data_phase;
   endfunction

   function automatic logic take_data_byte();
      if (data_left != 0) data_left--;
      return data_left == 0;
   endfunction

   task automatic walk_png_byte(input logic [7:0] b, input logic last,
                                output logic has_item, output profile_item_type item);
      logic        emit_payload;
      logic        emit_status;
      status_type  st;
      logic [2:0]  sig_pos;
      logic [32:0] seen;
      emit_payload = 1'b0;
      emit_status  = 1'b0;
      st           = ST_OK;
      has_item     = 1'b0;
      item         = '0;
      if (run_closed) begin
         if (last) clear_walker();
         return;
      end
      if (byte_tally < MIN_FILE) byte_tally++;
      case (walk_phase)
         PH_SIG: begin
            sig_pos = 3'(byte_tally - 5'd1);
            if (b != PNG_SIG[sig_pos]) begin
               emit_status = 1'b1;
               st = ST_SIGNATURE;
            end else if (sig_pos == 3'd7) begin
               walk_phase = PH_LEN;
               word_pos = '0;
            end
         end
         PH_LEN: begin
            walk_len = {walk_len[23:0], b};
            word_pos++;
            if (word_pos == 0) walk_phase = PH_TYPE;
         end
         PH_TYPE: begin
            chunk_tag = {chunk_tag[23:0], b};
            word_pos++;
            if (word_pos == 0) begin
               if (chunk_tag == TYPE_ICCP) begin
                  if (walk_len < 3) open_chunk_data(PH_BADSKIP, PH_CRC_BAD);
                  else open_chunk_data(PH_NAME, PH_CRC);
               end else begin
                  open_chunk_data(PH_SKIP, PH_CRC);
               end
            end
         end
         PH_NAME: begin
            if (take_data_byte()) walk_phase = PH_CRC_BAD;
            else if (b == 8'h00) walk_phase = PH_METHOD;
         end
         PH_METHOD: begin
            if (take_data_byte()) walk_phase = PH_CRC_BAD;
            else if (b != 8'h00) walk_phase = PH_BADSKIP;
            else walk_phase = PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            emit_payload = 1'b1;
            if (take_data_byte()) walk_phase = PH_CRC;
         end
         PH_SKIP: begin
            if (take_data_byte()) walk_phase = PH_CRC;
         end
         PH_BADSKIP: begin
            if (take_data_byte()) walk_phase = PH_CRC_BAD;
         end
         PH_CRC, PH_CRC_BAD: begin
            word_pos++;
            if (word_pos == 0) begin
               if (walk_phase == PH_CRC_BAD) begin
                  emit_status = 1'b1;
                  st = ST_MALFORMED;
               end else if (chunk_tag == TYPE_ICCP) begin
                  emit_status = 1'b1;
                  st = ST_OK;
               end else if (chunk_tag == TYPE_IEND) begin
                  emit_status = 1'b1;
                  st = ST_NO_ICCP;
               end else begin
                  walk_phase = PH_LEN;
               end
            end
         end
         default: ;
      endcase

      // End of file before a decision: classify by how far the current chunk got.
      if (!emit_status && last) begin
         seen = '0;
         if (walk_phase >= PH_NAME && walk_phase <= PH_BADSKIP)
            seen = {1'b0, walk_len} - {1'b0, data_left};
         else if (walk_phase == PH_CRC || walk_phase == PH_CRC_BAD)
            seen = {1'b0, walk_len} + 33'(word_pos);
         if (byte_tally < MIN_FILE || walk_phase == PH_SIG) st = ST_SIGNATURE;
         else if (seen >= 33'(HDR_TAIL)) st = ST_TRUNCATED;
         else st = ST_NO_ICCP;
         emit_status = 1'b1;
      end

      if (emit_status) begin
         has_item = 1'b1;
         item = '{8'h00, 1'b1, st};
         if (last) clear_walker();
         else run_closed = 1'b1;
      end else if (emit_payload) begin
         has_item = 1'b1;
         item = '{b, 1'b0, ST_OK};
      end
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_png_byte(input logic [7:0] b, input logic last, input logic no_gaps,
                                input row_kind_type kind, input profile_item_type typed);
      int               gap;
      logic             has_item;
      profile_item_type predicted;
      gap = no_gaps ? 0 : pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.data_byte <= b;
      req_ch.last_byte <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      live_bytes++;
      walk_png_byte(b, last, has_item, predicted);
      case (kind)
         ROW_PREDICT: if (has_item) profile_q.push_back(predicted);
         ROW_NONE:    ;
         default:     profile_q.push_back(typed);
      endcase
   endtask

   function automatic void append_word(logic [31:0] w);
      for (int i = 3; i >= 0; i--) file_q.push_back(w[8*i +: 8]);
   endfunction

   function automatic void append_random(int n, logic nonzero);
      repeat (n) body_q.push_back(nonzero ? 8'($urandom_range(1, 255)) : 8'($urandom()));
   endfunction

   function automatic logic [31:0] random_tag();
      logic [31:0] t;
      do t = $urandom(); while (t == TYPE_ICCP || t == TYPE_IEND);
      return t;
   endfunction

   // Emits the pending chunk body as one chunk with its length and a random CRC.
   function automatic void wrap_chunk(logic [31:0] tag);
      append_word(32'(body_q.size()));
      append_word(tag);
      foreach (body_q[i]) file_q.push_back(body_q[i]);
      append_word($urandom());
      body_q.delete();
   endfunction

   task automatic build_png_file();
      int flavor;
      int k;
      int cut;
      file_q.delete();
      body_q.delete();
      for (int i = 0; i < 8; i++) file_q.push_back(PNG_SIG[i]);
      flavor = $urandom_range(0, 99);
      if (flavor < 8) begin
         k = $urandom_range(0, 7);
         file_q[k] = file_q[k] ^ 8'($urandom_range(1, 255));
      end
      repeat ($urandom_range(0, 2)) begin
         append_random(($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6),
                       1'b0);
         wrap_chunk(random_tag());
      end
      if (flavor < 60) begin
         append_random($urandom_range(0, 6), 1'b1);
         body_q.push_back(8'h00);
         body_q.push_back(8'h00);
         append_random($urandom_range(1, 24), 1'b0);
         wrap_chunk(TYPE_ICCP);
      end else if (flavor < 82) begin
         k = $urandom_range(1, 5);
         case ($urandom_range(0, 4))
            0: append_random($urandom_range(0, 2), 1'b0);
            1: append_random($urandom_range(3, 8), 1'b1);
            2: begin
               append_random(k + 1, 1'b1);
               body_q.push_back(8'h00);
            end
            3: begin
               append_random(k, 1'b1);
               body_q.push_back(8'h00);
               body_q.push_back(8'($urandom_range(1, 255)));
               append_random($urandom_range(0, 4), 1'b0);
            end
            default: begin
               append_random(k, 1'b1);
               body_q.push_back(8'h00);
               body_q.push_back(8'h00);
            end
         endcase
         wrap_chunk(TYPE_ICCP);
      end else if (flavor < 90) begin
         if ($urandom_range(0, 1) == 1) begin
            wrap_chunk(TYPE_IEND);
         end else begin
            // Ends right at a chunk boundary with no profile seen.
            append_random($urandom_range(4, 10), 1'b0);
            wrap_chunk(random_tag());
         end
      end else if (flavor < 95) begin
         // A declared length near the top of the range; the file ends long before it.
         append_word(32'hffff_ffff - 32'($urandom_range(0, 15)));
         append_word(($urandom_range(0, 1) == 1) ? TYPE_ICCP : random_tag());
         repeat ($urandom_range(0, 12)) file_q.push_back(8'($urandom()));
      end else begin
         file_q.delete();
         repeat ($urandom_range(1, 30)) file_q.push_back(8'($urandom()));
      end
      if ($urandom_range(0, 2) == 0) wrap_chunk(TYPE_IEND);
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 6)) file_q.push_back(8'($urandom()));
      if ($urandom_range(0, 4) == 0) begin
         cut = $urandom_range(1, file_q.size());
         while (file_q.size() > cut) void'(file_q.pop_back());
      end
   endtask

   function automatic void note_mismatch(string msg);
      if (mismatches < 10) $display("%0t: %s", $time, msg);
      mismatches++;
   endfunction

   always @(posedge clock) begin
      profile_item_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_seen++;
         if (profile_q.size() == 0) begin
            note_mismatch($sformatf("unexpected result: byte %02h end %0b status %0d",
                                    rsp_ch.payload_byte, rsp_ch.is_end, rsp_ch.status));
         end else begin
            want = profile_q.pop_front();
            if (rsp_ch.payload_byte !== want.payload_byte || rsp_ch.is_end !== want.is_end ||
                rsp_ch.status !== want.status)
               note_mismatch($sformatf(
                  "result %0d: expected byte %02h end %0b status %0d, got %02h %0b %0d",
                  results_seen, want.payload_byte, want.is_end, want.status,
                  rsp_ch.payload_byte, rsp_ch.is_end, rsp_ch.status));
         end
      end
   end

   // Result side: random stalls, plus one long hold so the output stage fills.
   initial begin
      int   gap;
      int   run;
      logic held;
      held = 1'b0;
      rsp_ch.ready <= 1'b0;
      wait (!reset);
      forever begin
         gap = pick_gap();
         if (!held && results_seen >= 60) begin
            gap = LONG_HOLD;
            held = 1'b1;
         end
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         run = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
         repeat (run) @(posedge clock);
      end
   end

   initial begin
      #20_000_000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      directed_row_type row;
      profile_item_type typed_item;
      int               waited;
      int               target;
      logic             burst;
      req_ch.valid     <= 1'b0;
      req_ch.data_byte <= 8'h00;
      req_ch.last_byte <= 1'b0;
      clear_walker();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         typed_item.payload_byte = row.exp_byte;
         typed_item.is_end       = (row.kind == ROW_STATUS);
         typed_item.status       = row.exp_status;
         send_png_byte(row.data_byte, row.last_byte, 1'b0, row.kind, typed_item);
      end

      target = live_bytes + RANDOM_BYTES;
      while (live_bytes < target) begin
         build_png_file();
         burst = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < file_q.size(); i++)
            send_png_byte(file_q[i], i == file_q.size() - 1, burst, ROW_PREDICT, '0);
      end
      req_ch.valid <= 1'b0;

      waited = 0;
      while (profile_q.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (10) @(posedge clock);

      if (mismatches == 0 && profile_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         if (profile_q.size() != 0) $display("%0d expected results never arrived", profile_q.size());
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/iccpx_pkg.sv
hw/rtl/iccpx_if.sv
hw/rtl/iccpx_parser.sv
hw/rtl/iccpx_out_buf.sv
hw/rtl/png_iccp_chunk_extractor.sv
hw/rtl/iccpx_checker.sv
verif/tb_png_iccp_chunk_extractor.sv
